@@ src/tclp_pkg.sv @@
// Package for the text command line parser.
// Holds the keyword tables, status and command codes and register indexes.
// Depends on nothing.
`default_nettype none

package tclp_pkg;

   localparam int unsigned KwCount  = 4;
   localparam int unsigned PosCount = 8;

   typedef logic [1:0] status_type;
   typedef logic [1:0] command_type;
   typedef logic [1:0] csr_index_type;

   localparam status_type STATUS_DISPATCHED   = 2'd0;
   localparam status_type STATUS_FORMAT_ERROR = 2'd1;
   localparam status_type STATUS_UNKNOWN      = 2'd2;
   localparam status_type STATUS_OUT_OF_RANGE = 2'd3;

   localparam command_type CMD_LEDON  = 2'd0;
   localparam command_type CMD_LEDOFF = 2'd1;
   localparam command_type CMD_SERVO  = 2'd2;
   localparam command_type CMD_LCD    = 2'd3;

   localparam csr_index_type CSR_LED_LOW  = 2'd0;
   localparam csr_index_type CSR_LED_HIGH = 2'd1;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5a;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;

   localparam logic [7:0] LED_LOW_RESET  = 8'd0;
   localparam logic [7:0] LED_HIGH_RESET = 8'd3;

   // Keyword letters by position; a zero entry never matches a letter.
   localparam logic [7:0] KW_TEXT [0:KwCount-1][0:PosCount-1] = '{
      '{8'h4c, 8'h45, 8'h44, 8'h4f, 8'h4e, 8'h00, 8'h00, 8'h00},
      '{8'h4c, 8'h45, 8'h44, 8'h4f, 8'h46, 8'h46, 8'h00, 8'h00},
      '{8'h53, 8'h45, 8'h52, 8'h56, 8'h4f, 8'h00, 8'h00, 8'h00},
      '{8'h4c, 8'h43, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [0:KwCount-1] = '{3'd5, 3'd6, 3'd5, 3'd3};

endpackage : tclp_pkg

`default_nettype wire

@@ src/text_command_line_parser.sv @@
// Text command line parser top level: one character per transfer in,
// one result per line out. Depends on tclp_pkg for tables and codes.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_ch
//   rsp      out        rsp_valid/rsp_ready  rsp_status, rsp_command, rsp_value
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A character is registered on its transfer and decoded in the next cycle, so
// one character enters every cycle but for a waiting line end, which stays in the
// input register only while the single result register still holds an untaken result.
// Reset clears the line state and loads the LED range registers with 0 and 3.
// The configuration channel is always ready.
`default_nettype none

module text_command_line_parser
   import tclp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_ch,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output status_type         rsp_status,
   output command_type        rsp_command,
   output logic [7:0]         rsp_value,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_data
);

   typedef enum logic [1:0] {
      PH_LETTERS = 2'd0,
      PH_DIGITS  = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_ch_ff;
   phase_type         phase_ff, phase_in;
   logic [2:0]        pos_ff, pos_in;
   logic [KwCount-1:0] match_ff, match_in;
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        led_low_ff, led_high_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   command_type       rsp_command_ff, rsp_command_in;
   logic [7:0]        rsp_value_ff, rsp_value_in;
   logic              is_end;
   logic              advance;
   logic [3:0]        digit;

   assign is_end    = (in_ch_ff == CHAR_END);
   assign advance   = in_valid_ff && (!is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign digit     = 4'(in_ch_ff - CHAR_0);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_value   = rsp_value_ff;

   always_comb begin
      in_valid_in    = (in_valid_ff && !advance) || (req_valid && req_ready);
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      match_in       = match_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_command_in = rsp_command_ff;
      rsp_value_in   = rsp_value_ff;
      if (advance && !is_end) begin
         unique case (phase_ff)
            PH_LETTERS: begin
               if (in_ch_ff >= CHAR_A && in_ch_ff <= CHAR_Z) begin
                  for (int k = 0; k < KwCount; k++) begin
                     if (KW_TEXT[k][pos_ff] != in_ch_ff) begin
                        match_in[k] = 1'b0;
                     end
                  end
                  if (pos_ff != 3'd7) begin
                     pos_in = pos_ff + 3'd1;
                  end
               end else if (in_ch_ff == CHAR_SPACE) begin
                  for (int k = 0; k < KwCount; k++) begin
                     if (KW_LEN[k] != pos_ff) begin
                        match_in[k] = 1'b0;
                     end
                  end
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_DIGITS: begin
               if (in_ch_ff >= CHAR_0 && in_ch_ff <= CHAR_9) begin
                  acc_in = {acc_ff[4:0], 3'b000} + {acc_ff[6:0], 1'b0} + {4'b0000, digit};
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STATUS_FORMAT_ERROR;
         rsp_command_in = CMD_LEDON;
         rsp_value_in   = 8'd0;
         if (phase_ff == PH_DIGITS) begin
            rsp_value_in = acc_ff;
            if (match_ff == '0) begin
               rsp_status_in = STATUS_UNKNOWN;
            end else begin
               priority if (match_ff[0]) begin
                  rsp_command_in = CMD_LEDON;
               end else if (match_ff[1]) begin
                  rsp_command_in = CMD_LEDOFF;
               end else if (match_ff[2]) begin
                  rsp_command_in = CMD_SERVO;
               end else begin
                  rsp_command_in = CMD_LCD;
               end
               if ((rsp_command_in == CMD_LEDON || rsp_command_in == CMD_LEDOFF) &&
                   (acc_ff < led_low_ff || acc_ff > led_high_ff)) begin
                  rsp_status_in = STATUS_OUT_OF_RANGE;
               end else begin
                  rsp_status_in = STATUS_DISPATCHED;
               end
            end
         end
         phase_in = PH_LETTERS;
         pos_in   = 3'd0;
         match_in = '1;
         acc_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_LETTERS;
         pos_ff       <= 3'd0;
         match_ff     <= '1;
         acc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
         led_low_ff   <= LED_LOW_RESET;
         led_high_ff  <= LED_HIGH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         match_ff     <= match_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == CSR_LED_LOW) begin
            led_low_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_LED_HIGH) begin
            led_high_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_command_ff <= rsp_command_in;
      rsp_value_ff   <= rsp_value_in;
   end

endmodule : text_command_line_parser

`default_nettype wire

@@ verif/tb.sv @@
// Testbench for text_command_line_parser: self-checking, with its own line decoder.
// It drives directed and random text lines, LED range settings and back-pressure.
// It depends on tclp_pkg and the text_command_line_parser RTL.
`timescale 1ns / 100ps

module tb;
   import tclp_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int SEGMENT_CHARS = 45;
   localparam logic [7:0] LOW_AT_RESET = 8'd0;
   localparam logic [7:0] HIGH_AT_RESET = 8'd3;
   localparam csr_index_type CSR_SPARE_2 = 2'd2;
   localparam csr_index_type CSR_SPARE_3 = 2'd3;

   typedef enum logic [1:0] {
      PH_LETTERS = 2'd0,
      PH_DIGITS  = 2'd1,
      PH_BAD     = 2'd2
   } line_phase_type;

   typedef struct packed {
      status_type  status;
      command_type command;
      logic [7:0]  value;
   } line_result_type;

   typedef struct {
      string           text;
      bit              typed_on;
      line_result_type typed;
   } line_case_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [7:0]    req_ch;
   logic          rsp_valid;
   logic          rsp_ready;
   status_type    rsp_status;
   command_type   rsp_command;
   logic [7:0]    rsp_value;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_data;

   logic            drv_has_typed;
   line_result_type drv_typed;

   string kw_names [4] = '{"LEDON", "LEDOFF", "SERVO", "LCD"};

   line_case_type directed_lines [16] = '{
      '{"",             1'b1, '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0}},
      '{"LEDON 3",      1'b1, '{STATUS_DISPATCHED, CMD_LEDON, 8'd3}},
      '{"LEDOFF 4",     1'b1, '{STATUS_OUT_OF_RANGE, CMD_LEDOFF, 8'd4}},
      '{"LEDOFF 0",     1'b1, '{STATUS_DISPATCHED, CMD_LEDOFF, 8'd0}},
      '{"SERVO 255",    1'b1, '{STATUS_DISPATCHED, CMD_SERVO, 8'd255}},
      '{"LCD ",         1'b1, '{STATUS_DISPATCHED, CMD_LCD, 8'd0}},
      '{"SERVO 1000",   1'b0, '0},
      '{" 7",           1'b1, '{STATUS_UNKNOWN, CMD_LEDON, 8'd7}},
      '{"ABCDEFGHIJ 5", 1'b1, '{STATUS_UNKNOWN, CMD_LEDON, 8'd5}},
      '{"LEDONX 1",     1'b1, '{STATUS_UNKNOWN, CMD_LEDON, 8'd1}},
      '{"LED 2",        1'b0, '0},
      '{"LEDON",        1'b1, '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0}},
      '{"SERVO 1 2",    1'b1, '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0}},
      '{"lcd 9",        1'b1, '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0}},
      '{"LCD\377 1",    1'b1, '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0}},
      '{"LEDON 99999",  1'b0, '0}
   };

   line_phase_type  pr_phase;
   logic [2:0]      pr_pos;
   logic [3:0]      pr_match;
   logic [7:0]      pr_num;
   logic [7:0]      pr_led_low;
   logic [7:0]      pr_led_high;
   line_result_type expected_results [$];

   int          mismatches;
   int          chars_sent;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          hold_orders;
   int unsigned cycle_count;

   text_command_line_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_command (rsp_command),
      .rsp_value   (rsp_value),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_line();
      pr_phase = PH_LETTERS;
      pr_pos = 3'd0;
      pr_match = 4'hf;
      pr_num = 8'd0;
   endfunction

   function automatic void apply_setting_write(input csr_index_type idx, input logic [7:0] data);
      case (idx)
         CSR_LED_LOW: pr_led_low = data;
         CSR_LED_HIGH: pr_led_high = data;
         default: ;
      endcase
   endfunction

   // Advances the line decoder by one character; returns 1 when the line ends.
   function automatic bit decode_char(input logic [7:0] c, output line_result_type res);
      bit found;
      found = 1'b0;
      res = '{STATUS_FORMAT_ERROR, CMD_LEDON, 8'd0};
      if (c != CHAR_END) begin
         case (pr_phase)
            PH_LETTERS: begin
               if (c >= CHAR_A && c <= CHAR_Z) begin
                  for (int k = 0; k < 4; k++) begin
                     if (pr_pos >= kw_names[k].len() || kw_names[k][pr_pos] != c) begin
                        pr_match[k] = 1'b0;
                     end
                  end
                  if (pr_pos != 3'd7) begin
                     pr_pos = pr_pos + 3'd1;
                  end
               end else if (c == CHAR_SPACE) begin
                  for (int k = 0; k < 4; k++) begin
                     if (kw_names[k].len() != pr_pos) begin
                        pr_match[k] = 1'b0;
                     end
                  end
                  pr_phase = PH_DIGITS;
               end else begin
                  pr_phase = PH_BAD;
               end
            end
            PH_DIGITS: begin
               if (c >= CHAR_0 && c <= CHAR_9) begin
                  pr_num = pr_num * 8'd10 + (c - CHAR_0);
               end else begin
                  pr_phase = PH_BAD;
               end
            end
            default: ;
         endcase
         return 1'b0;
      end
      if (pr_phase == PH_DIGITS) begin
         res.value = pr_num;
         if (pr_match == 4'd0) begin
            res.status = STATUS_UNKNOWN;
         end else begin
            for (int k = 0; k < 4; k++) begin
               if (!found && pr_match[k]) begin
                  res.command = command_type'(k);
                  found = 1'b1;
               end
            end
            if ((res.command == CMD_LEDON || res.command == CMD_LEDOFF) &&
                (pr_num < pr_led_low || pr_num > pr_led_high)) begin
               res.status = STATUS_OUT_OF_RANGE;
            end else begin
               res.status = STATUS_DISPATCHED;
            end
         end
      end
      clear_line();
      return 1'b1;
   endfunction

   initial begin
      pr_led_low = LOW_AT_RESET;
      pr_led_high = HIGH_AT_RESET;
      clear_line();
      mismatches = 0;
   end

   always @(posedge clock) begin
      line_result_type predicted;
      line_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_setting_write(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            if (decode_char(req_ch, predicted)) begin
               expected_results.push_back(drv_has_typed ? drv_typed : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, actual status %0d command %0d value %0d",
                        $time, rsp_status, rsp_command, rsp_value);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status != want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_command != want.command) begin
                  $display("%0t: command mismatch, expected %0d actual %0d",
                           $time, want.command, rsp_command);
                  mismatches++;
               end
               if (rsp_value != want.value) begin
                  $display("%0t: value mismatch, expected %0d actual %0d",
                           $time, want.value, rsp_value);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c, input bit typed_on,
                            input line_result_type typed);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      drv_has_typed <= typed_on;
      drv_typed <= typed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_line(input logic [7:0] chars [$], input bit typed_on,
                            input line_result_type typed);
      foreach (chars[i]) begin
         send_char(chars[i], 1'b0, '0);
      end
      send_char(CHAR_END, typed_on, typed);
   endtask

   task automatic send_random_line();
      logic [7:0] chars [$];
      string kw_text;
      string digits;
      int kind;
      int num;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         kw_text = kw_names[$urandom_range(0, 3)];
         for (int i = 0; i < kw_text.len(); i++) begin
            chars.push_back(kw_text[i]);
         end
         chars.push_back(CHAR_SPACE);
         case ($urandom_range(0, 7))
            0: num = -1;
            1: num = int'(pr_led_low) - 1;
            2: num = int'(pr_led_low);
            3: num = int'(pr_led_high);
            4: num = int'(pr_led_high) + 1;
            default: num = $urandom_range(0, 999);
         endcase
         if (num >= 0) begin
            digits = $sformatf("%0d", num);
            for (int i = 0; i < digits.len(); i++) begin
               chars.push_back(digits[i]);
            end
         end
         if (kind >= 65) begin
            chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(1, 255)));
         end
      end else begin
         repeat ($urandom_range(0, 8)) chars.push_back(8'($urandom_range(1, 255)));
      end
      send_line(chars, 1'b0, '0);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_led_range(input logic [7:0] low, input logic [7:0] high);
      write_csr(CSR_LED_LOW, low);
      write_csr(CSR_LED_HIGH, high);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_3 : CSR_SPARE_2, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] chars [$];
      int target;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_ch <= CHAR_END;
      drv_has_typed <= 1'b0;
      drv_typed <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_LED_LOW;
      csr_data <= 8'd0;
      chars_sent = 0;
      hold_orders = 0;
      req_idle_pct = 14;
      rsp_idle_pct = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[r]) begin
         chars.delete();
         for (int i = 0; i < directed_lines[r].text.len(); i++) begin
            chars.push_back(directed_lines[r].text[i]);
         end
         send_line(chars, directed_lines[r].typed_on, directed_lines[r].typed);
      end

      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         case (seg)
            0: set_led_range(8'd0, 8'd255);
            1: set_led_range(8'd255, 8'd0);
            2: set_led_range(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            3: set_led_range(8'd255, 8'd255);
            4: set_led_range(8'd0, 8'd0);
            default: set_led_range(8'd1, 8'd9);
         endcase
         if (seg == 2) begin
            req_idle_pct = 51;
            rsp_idle_pct = 14;
         end
         if (seg == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_orders++;
         end
         target = chars_sent + SEGMENT_CHARS;
         while (chars_sent < target) send_random_line();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : tb
